[sv/vgpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_pkg - shared types and constants for the volume gain and peak meter
// Field widths, format codes, register indexes and the peak store control
// bundle passed from the top level to the peak store.
// ----------------------------------------------------------------------------
package vgpm_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int SAMPLE_W   = 32;
    localparam int CHAN_W     = 3;
    localparam int GAIN_W     = 31;
    localparam int PEAK_W     = 32;
    localparam int FMT_W      = 2;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 64;
    localparam int IDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // sign bit positions of the three sample formats
    localparam int TOP_16 = 15;
    localparam int TOP_24 = 23;
    localparam int TOP_32 = 31;

    localparam logic [PEAK_W-1:0] PEAK_SAT = 32'h7FFF_FFFF;

    // sample_format codes; the unused code behaves as 32-bit
    localparam logic [FMT_W-1:0] FMT_16 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_24 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_SHIFT    = 4'd1;

    typedef struct packed {
        logic              update;
        logic              clear;
        logic [CHAN_W-1:0] channel;
    } peak_ctl_t;

endpackage
`default_nettype wire

[sv/vgpm_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_scale - gain multiply, rounding and saturation
// Registers the signed sample times gain product, then rounds half up,
// drops the fraction bits and clamps to the selected sample format.
// ----------------------------------------------------------------------------
module vgpm_scale (
    input  wire logic                                  clk,
    input  wire logic                                  load,
    input  wire logic signed [vgpm_pkg::SAMPLE_W-1:0]  x,
    input  wire logic        [vgpm_pkg::GAIN_W-1:0]    gain,
    input  wire logic        [vgpm_pkg::FMT_W-1:0]     fmt,
    output logic signed      [vgpm_pkg::SAMPLE_W-1:0]  result
);
    import vgpm_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd1 <<< (GAIN_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] hi_lim;
    logic signed [PROD_W-1:0] lo_lim;
    logic signed [PROD_W-1:0] clamped;

    always_comb
    begin
        prod_next = PROD_W'(x) * PROD_W'($signed({1'b0, gain}));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        case (fmt)
            FMT_16:
            begin
                hi_lim = (64'sd1 <<< TOP_16) - 64'sd1;
                lo_lim = -(64'sd1 <<< TOP_16);
            end
            FMT_24:
            begin
                hi_lim = (64'sd1 <<< TOP_24) - 64'sd1;
                lo_lim = -(64'sd1 <<< TOP_24);
            end
            default:
            begin
                hi_lim = (64'sd1 <<< TOP_32) - 64'sd1;
                lo_lim = -(64'sd1 <<< TOP_32);
            end
        endcase

        rounded = (prod_reg + ROUND_HALF) >>> GAIN_FRAC_BITS;

        if (rounded > hi_lim)
        begin
            clamped = hi_lim;
        end
        else if (rounded < lo_lim)
        begin
            clamped = lo_lim;
        end
        else
        begin
            clamped = rounded;
        end

        result = clamped[SAMPLE_W-1:0];
    end

endmodule
`default_nettype wire

[sv/vgpm_peak.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_peak - per-channel peak store
// Forms the saturated magnitude of a sample, shifted unless the format is
// 16-bit, raises the channel's stored peak to it and returns the updated
// peak. A block start clears every entry before the update.
// ----------------------------------------------------------------------------
module vgpm_peak (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire vgpm_pkg::peak_ctl_t                  ctl,
    input  wire logic signed [vgpm_pkg::SAMPLE_W-1:0] x,
    input  wire logic        [vgpm_pkg::FMT_W-1:0]    fmt,
    input  wire logic        [vgpm_pkg::SHIFT_W-1:0]  shift,
    output logic             [vgpm_pkg::PEAK_W-1:0]   peak
);
    import vgpm_pkg::*;

    localparam int CH_EXT_W = CHAN_W + IDX_W;

    logic [PEAK_W-1:0]         store_reg  [MAX_CHANNELS];
    logic [PEAK_W-1:0]         store_next [MAX_CHANNELS];
    logic signed [SAMPLE_W:0]  x_ext;
    logic [SAMPLE_W:0]         abs_val;
    logic [PEAK_W-2:0]         mag_lim;
    logic [2*PEAK_W-2:0]       mag_wide;
    logic [PEAK_W-1:0]         mag_shifted;
    logic [PEAK_W-1:0]         mag;
    logic [CH_EXT_W-1:0]       ch_ext;
    logic                      in_range;
    logic [IDX_W-1:0]          idx;
    logic [PEAK_W-1:0]         current;
    logic [PEAK_W-1:0]         updated;

    always_comb
    begin
        x_ext   = {x[SAMPLE_W-1], x};
        abs_val = (x_ext < 0) ? (SAMPLE_W + 1)'(-x_ext) : x_ext;
        // most negative 32-bit value clamps to full scale
        mag_lim = (abs_val > (SAMPLE_W + 1)'(PEAK_SAT)) ? PEAK_SAT[PEAK_W-2:0]
                                                         : abs_val[PEAK_W-2:0];

        mag_wide    = (2*PEAK_W - 1)'(mag_lim) << shift;
        mag_shifted = (|mag_wide[2*PEAK_W-2:PEAK_W-1]) ? PEAK_SAT
                                                       : {1'b0, mag_wide[PEAK_W-2:0]};
        mag         = (fmt == FMT_16) ? {1'b0, mag_lim} : mag_shifted;

        ch_ext   = CH_EXT_W'(ctl.channel);
        in_range = ch_ext < CH_EXT_W'(MAX_CHANNELS);
        idx      = ch_ext[IDX_W-1:0];

        current = ctl.clear ? '0 : store_reg[idx];
        updated = (mag > current) ? mag : current;
        peak    = in_range ? updated : '0;

        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            store_next[i] = ctl.clear ? '0 : store_reg[i];
        end
        if (in_range)
        begin
            store_next[idx] = updated;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (ctl.update)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule
`default_nettype wire

[sv/volume_gain_with_peak_meter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// volume_gain_with_peak_meter - fixed-point volume gain with peak metering
// Scales each sample by its channel gain with rounding and saturation and
// reports the channel's running peak magnitude.
// ----------------------------------------------------------------------------
// The block takes one sample transfer per clock while the output side is not
// stalled and returns one result per sample, in order. The pipeline is an
// input register, the registered 32x32 gain product (with the peak store
// updated on the same edge), and the output register; a stall on the output
// only holds stages that are full, so empty stages keep taking samples.
// Configuration is taken on any cycle and must be written while no sample is
// in flight.
module volume_gain_with_peak_meter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [63:0]                        s_tdata,   // sample[31:0], gain[62:32], zero
    input  wire logic [3:0]                         s_tuser,   // channel[2:0], block_start[3]
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [63:0]                             m_tdata,   // scaled_sample[31:0], peak_level[63:32]
    output logic [2:0]                              m_tuser,   // out_channel[2:0]
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vgpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vgpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vgpm_pkg::*;

    logic [FMT_W-1:0]          fmt_reg;
    logic [SHIFT_W-1:0]        shift_reg;

    logic                      v1_reg;
    logic [SAMPLE_W-1:0]       sample1_reg;
    logic [CHAN_W-1:0]         chan1_reg;
    logic [GAIN_W-1:0]         gain1_reg;
    logic                      start1_reg;

    logic                      v2_reg;
    logic [CHAN_W-1:0]         chan2_reg;
    logic [PEAK_W-1:0]         peak2_reg;

    logic                      v3_reg;
    logic [SAMPLE_W-1:0]       scaled3_reg;
    logic [CHAN_W-1:0]         chan3_reg;
    logic [PEAK_W-1:0]         peak3_reg;

    logic                      en1;
    logic                      en2;
    logic                      en3;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [PEAK_W-1:0]         peak;
    peak_ctl_t                 peak_ctl;

    // each stage advances when it or the next one has room
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_32;
            shift_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SAMPLE_FORMAT: fmt_reg   <= cfg_data[FMT_W-1:0];
                REG_PEAK_SHIFT:    shift_reg <= cfg_data[SHIFT_W-1:0];
                default:           ;
            endcase
        end
    end

    // reduce the raw sample to the selected format
    always_comb
    begin
        case (fmt_reg)
            FMT_16:  x1 = SAMPLE_W'($signed(sample1_reg[TOP_16:0]));
            FMT_24:  x1 = SAMPLE_W'($signed(sample1_reg[TOP_24:0]));
            default: x1 = $signed(sample1_reg);
        endcase
    end

    always_comb
    begin
        peak_ctl.update  = en2 && v1_reg;
        peak_ctl.clear   = start1_reg;
        peak_ctl.channel = chan1_reg;
    end

    vgpm_scale u_scale (
        .clk    (clk),
        .load   (en2 && v1_reg),
        .x      (x1),
        .gain   (gain1_reg),
        .fmt    (fmt_reg),
        .result (scaled)
    );

    vgpm_peak u_peak (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (peak_ctl),
        .x     (x1),
        .fmt   (fmt_reg),
        .shift (shift_reg),
        .peak  (peak)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            sample1_reg <= s_tdata[SAMPLE_W-1:0];
            gain1_reg   <= s_tdata[SAMPLE_W+GAIN_W-1:SAMPLE_W];
            chan1_reg   <= s_tuser[CHAN_W-1:0];
            start1_reg  <= s_tuser[CHAN_W];
        end
        if (en2 && v1_reg)
        begin
            chan2_reg <= chan1_reg;
            peak2_reg <= peak;
        end
        if (en3 && v2_reg)
        begin
            scaled3_reg <= scaled;
            chan3_reg   <= chan2_reg;
            peak3_reg   <= peak2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {peak3_reg, scaled3_reg};
    assign m_tuser  = chan3_reg;

    // an empty output stage must leave the input open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // an accepted sample always lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted sample lost at input stage");

    // peak never exceeds full scale
    a_peak_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[63])
        else $error("peak level above saturation limit");

    // 16-bit results are sign-extended from bit 15
    a_fmt16_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (fmt_reg == FMT_16) |-> (m_tdata[31:15] == {17{m_tdata[15]}}))
        else $error("16-bit result out of range");

endmodule
`default_nettype wire
